// ===== hdl/cfe_pkg.sv =====
// shared types, constants and helper functions of the convolution engine
package cfe_pkg;

  localparam int MAX_IN_CHANNELS  = 4;
  localparam int MAX_OUT_CHANNELS = 8;
  localparam int MAX_KERNEL       = 5;
  localparam int MAX_HEIGHT       = 64;
  localparam int MAX_WIDTH        = 64;

  localparam int KER_AREA  = MAX_KERNEL * MAX_KERNEL;
  localparam int IMG_DEPTH = MAX_IN_CHANNELS * MAX_HEIGHT * MAX_WIDTH;
  localparam int WGT_DEPTH = MAX_OUT_CHANNELS * MAX_IN_CHANNELS * KER_AREA;
  localparam int IMG_AW    = $clog2(IMG_DEPTH);
  localparam int WGT_AW    = $clog2(WGT_DEPTH);
  localparam int ACC_W     = 40;
  localparam int CFG_W     = 7;
  localparam int CFG_IW    = 3;

  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_WEIGHT = 2'd1;
  localparam logic [1:0] KIND_BIAS   = 2'd2;
  localparam logic [1:0] KIND_QUERY  = 2'd3;

  localparam logic [CFG_IW-1:0] REG_NIN    = 3'd0;
  localparam logic [CFG_IW-1:0] REG_NOUT   = 3'd1;
  localparam logic [CFG_IW-1:0] REG_KSIDE  = 3'd2;
  localparam logic [CFG_IW-1:0] REG_STEP   = 3'd3;
  localparam logic [CFG_IW-1:0] REG_PAD    = 3'd4;
  localparam logic [CFG_IW-1:0] REG_DIL    = 3'd5;
  localparam logic [CFG_IW-1:0] REG_HEIGHT = 3'd6;
  localparam logic [CFG_IW-1:0] REG_WIDTH  = 3'd7;

  localparam logic signed [23:0] OUT_MAX = 24'sh7fffff;
  localparam logic signed [23:0] OUT_MIN = -24'sh800000;

  typedef struct packed {
    logic accept;    // input request taken this cycle
    logic clear_en;  // weight store clearing pass
    logic step;      // issue one tap
    logic load_out;  // load result register
  } cfe_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic query_oor;
    logic iter_last;
    logic pipe_busy;
    logic out_free;
  } cfe_stat_t;

  function automatic logic [15:0] sat16(input logic signed [31:0] v);
    logic [15:0] r;
    if (v > 32'sd32767)       r = 16'h7fff;
    else if (v < -32'sd32768) r = 16'h8000;
    else                      r = v[15:0];
    return r;
  endfunction

  function automatic logic [WGT_AW-1:0] wgt_addr(input logic [2:0] oc, input logic [1:0] ic,
                                                 input logic [2:0] kr, input logic [2:0] kc);
    logic [WGT_AW-1:0] row_base;
    logic [WGT_AW-1:0] tap;
    row_base = WGT_AW'({oc, ic}) * WGT_AW'(KER_AREA);
    tap      = WGT_AW'(kr) * WGT_AW'(MAX_KERNEL) + WGT_AW'(kc);
    return row_base + tap;
  endfunction

endpackage

// ===== hdl/cfe_if.sv =====
// valid/ready channel interfaces for requests and results
interface cfe_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [1:0]         in_chan;
  logic [2:0]         out_chan;
  logic [5:0]         row_pos;
  logic [5:0]         col_pos;
  logic [2:0]         tap_row;
  logic [2:0]         tap_col;
  logic signed [31:0] value;
  modport source (output valid, kind, in_chan, out_chan, row_pos, col_pos, tap_row, tap_col,
                  value, input ready);
  modport sink (input valid, kind, in_chan, out_chan, row_pos, col_pos, tap_row, tap_col,
                value, output ready);
endinterface

interface cfe_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] conv_value;
  logic               saturated;
  logic               out_of_range;
  modport source (output valid, conv_value, saturated, out_of_range, input ready);
  modport sink (input valid, conv_value, saturated, out_of_range, output ready);
endinterface

// ===== hdl/cfe_ram.sv =====
// generic simple dual-port ram with registered read
module cfe_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/cfe_ctrl.sv =====
// controller state machine: clearing pass, request intake, tap walk and result hand-off
module cfe_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        in_kind,
  output logic              in_ready,
  input  cfe_pkg::cfe_stat_t stat,
  output cfe_pkg::cfe_cmd_t  cmd
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_RUN   = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear_en = 1'b1;
        if (stat.clear_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (in_kind == cfe_pkg::KIND_QUERY) begin
            state_nxt = stat.query_oor ? ST_FIN : ST_RUN;
          end
        end
      end
      ST_RUN: begin
        cmd.step = 1'b1;
        if (stat.iter_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!stat.pipe_busy) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_CLEAR;
    else        state_r <= state_nxt;
  end

endmodule

// ===== hdl/cfe_datapath.sv =====
// datapath: config registers, stores, tap addressing, multiply-accumulate and result register
module cfe_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [cfe_pkg::CFG_IW-1:0]        cfg_index,
  input  logic [cfe_pkg::CFG_W-1:0]         cfg_data,
  input  logic [1:0]                        in_kind,
  input  logic [1:0]                        in_in_chan,
  input  logic [2:0]                        in_out_chan,
  input  logic [5:0]                        in_row_pos,
  input  logic [5:0]                        in_col_pos,
  input  logic [2:0]                        in_tap_row,
  input  logic [2:0]                        in_tap_col,
  input  logic signed [31:0]                in_value,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic signed [23:0]                out_conv_value,
  output logic                              out_saturated,
  output logic                              out_out_of_range,
  input  cfe_pkg::cfe_cmd_t                  cmd,
  output cfe_pkg::cfe_stat_t                 stat
);

  // config registers
  logic [2:0] nin_r, ksd_r, step_r, dil_r;
  logic [3:0] nout_r;
  logic [1:0] pad_r;
  logic [6:0] hgt_r, wid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nin_r  <= 3'd1;
      nout_r <= 4'd1;
      ksd_r  <= 3'd3;
      step_r <= 3'd1;
      pad_r  <= 2'd0;
      dil_r  <= 3'd1;
      hgt_r  <= 7'd64;
      wid_r  <= 7'd64;
    end else if (cfg_we) begin
      case (cfg_index)
        cfe_pkg::REG_NIN:    nin_r  <= cfg_data[2:0];
        cfe_pkg::REG_NOUT:   nout_r <= cfg_data[3:0];
        cfe_pkg::REG_KSIDE:  ksd_r  <= cfg_data[2:0];
        cfe_pkg::REG_STEP:   step_r <= cfg_data[2:0];
        cfe_pkg::REG_PAD:    pad_r  <= cfg_data[1:0];
        cfe_pkg::REG_DIL:    dil_r  <= cfg_data[2:0];
        cfe_pkg::REG_HEIGHT: hgt_r  <= cfg_data[6:0];
        cfe_pkg::REG_WIDTH:  wid_r  <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // clamped views
  logic [2:0] nin_c, k_c, s_c, d_c;
  logic [3:0] nout_c;
  logic [1:0] p_c;
  logic [6:0] h_c, w_c;

  always_comb begin
    nin_c  = (nin_r == 3'd0) ? 3'd1 : ((nin_r > 3'd4) ? 3'd4 : nin_r);
    nout_c = (nout_r == 4'd0) ? 4'd1 : ((nout_r > 4'd8) ? 4'd8 : nout_r);
    k_c    = (ksd_r == 3'd0) ? 3'd1 : ((ksd_r > 3'd5) ? 3'd5 : ksd_r);
    s_c    = (step_r == 3'd0) ? 3'd1 : ((step_r > 3'd4) ? 3'd4 : step_r);
    p_c    = (pad_r > 2'd2) ? 2'd2 : pad_r;
    d_c    = (dil_r == 3'd0) ? 3'd1 : ((dil_r > 3'd4) ? 3'd4 : dil_r);
    h_c    = (hgt_r == 7'd0) ? 7'd1 : ((hgt_r > 7'd64) ? 7'd64 : hgt_r);
    w_c    = (wid_r == 7'd0) ? 7'd1 : ((wid_r > 7'd64) ? 7'd64 : wid_r);
  end

  // range check: position r is inside when r*s <= n + 2p - d*(k-1) - 1
  logic [4:0]        span;
  logic signed [9:0] num_h, num_w;
  logic [8:0]        row_s, col_s;
  logic signed [9:0] pad2;
  logic              oor;

  always_comb begin
    span  = 5'(d_c * (k_c - 3'd1));
    pad2  = 10'($unsigned({p_c, 1'b0}));
    num_h = $signed({3'b0, h_c}) + pad2 - $signed({5'b0, span}) - 10'sd1;
    num_w = $signed({3'b0, w_c}) + pad2 - $signed({5'b0, span}) - 10'sd1;
    row_s = 9'(in_row_pos * s_c);
    col_s = 9'(in_col_pos * s_c);
    oor   = ({1'b0, in_out_chan} >= nout_c) || (num_h < 10'sd0) || (num_w < 10'sd0) ||
            ($signed({1'b0, row_s}) > num_h) || ($signed({1'b0, col_s}) > num_w);
  end
  assign stat.query_oor = oor;

  logic acc_write, is_query;
  assign acc_write = cmd.accept;
  assign is_query  = cmd.accept && (in_kind == cfe_pkg::KIND_QUERY);

  // bias store
  logic signed [31:0] bias_r [cfe_pkg::MAX_OUT_CHANNELS];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < cfe_pkg::MAX_OUT_CHANNELS; i++) bias_r[i] <= '0;
    end else if (acc_write && in_kind == cfe_pkg::KIND_BIAS) begin
      bias_r[in_out_chan] <= in_value;
    end
  end

  // query context and tap counters
  logic [2:0]        oc_r;
  logic              oor_r;
  logic signed [9:0] rbase_r, cbase_r;
  logic [1:0]        ch_r;
  logic [2:0]        kr_r, kc_r;
  logic              kc_last, kr_last, ch_last;

  assign kc_last        = (kc_r == k_c - 3'd1);
  assign kr_last        = (kr_r == k_c - 3'd1);
  assign ch_last        = ({1'b0, ch_r} == nin_c - 3'd1);
  assign stat.iter_last = kc_last && kr_last && ch_last;

  always_ff @(posedge clk) begin
    if (is_query) begin
      oc_r    <= in_out_chan;
      oor_r   <= oor;
      rbase_r <= $signed({1'b0, row_s}) - $signed({8'b0, p_c});
      cbase_r <= $signed({1'b0, col_s}) - $signed({8'b0, p_c});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_r <= '0;
      kr_r <= '0;
      kc_r <= '0;
    end else if (is_query) begin
      ch_r <= '0;
      kr_r <= '0;
      kc_r <= '0;
    end else if (cmd.step) begin
      if (kc_last) begin
        kc_r <= '0;
        if (kr_last) begin
          kr_r <= '0;
          ch_r <= ch_r + 2'd1;
        end else begin
          kr_r <= kr_r + 3'd1;
        end
      end else begin
        kc_r <= kc_r + 3'd1;
      end
    end
  end

  // tap coordinates
  logic signed [9:0] ih, iw;
  logic              tap_ok;
  always_comb begin
    ih     = rbase_r + $signed({5'b0, 5'(kr_r * d_c)});
    iw     = cbase_r + $signed({5'b0, 5'(kc_r * d_c)});
    tap_ok = (ih >= 10'sd0) && (ih < $signed({3'b0, h_c})) &&
             (iw >= 10'sd0) && (iw < $signed({3'b0, w_c}));
  end

  // clearing pass counter
  logic [cfe_pkg::WGT_AW-1:0] clr_r;
  assign stat.clear_last = (clr_r == cfe_pkg::WGT_AW'(cfe_pkg::WGT_DEPTH - 1));
  always_ff @(posedge clk) begin
    if (!rst_n)            clr_r <= '0;
    else if (cmd.clear_en) clr_r <= clr_r + 1'b1;
  end

  // weight store
  logic                       wgt_we;
  logic [cfe_pkg::WGT_AW-1:0] wgt_waddr;
  logic [15:0]                wgt_wdata, wgt_rdata;
  always_comb begin
    if (cmd.clear_en) begin
      wgt_we    = 1'b1;
      wgt_waddr = clr_r;
      wgt_wdata = '0;
    end else begin
      wgt_we    = acc_write && (in_kind == cfe_pkg::KIND_WEIGHT) &&
                  (in_tap_row < 3'(cfe_pkg::MAX_KERNEL)) &&
                  (in_tap_col < 3'(cfe_pkg::MAX_KERNEL));
      wgt_waddr = cfe_pkg::wgt_addr(in_out_chan, in_in_chan, in_tap_row, in_tap_col);
      wgt_wdata = cfe_pkg::sat16(in_value);
    end
  end

  cfe_ram #(.WIDTH(16), .DEPTH(cfe_pkg::WGT_DEPTH)) u_wgt_ram (
    .clk   (clk),
    .we    (wgt_we),
    .waddr (wgt_waddr),
    .wdata (wgt_wdata),
    .raddr (cfe_pkg::wgt_addr(oc_r, ch_r, kr_r, kc_r)),
    .rdata (wgt_rdata)
  );

  // image store
  logic [15:0] img_rdata;
  cfe_ram #(.WIDTH(16), .DEPTH(cfe_pkg::IMG_DEPTH)) u_img_ram (
    .clk   (clk),
    .we    (acc_write && in_kind == cfe_pkg::KIND_SAMPLE),
    .waddr ({in_in_chan, in_row_pos, in_col_pos}),
    .wdata (cfe_pkg::sat16(in_value)),
    .raddr ({ch_r, ih[5:0], iw[5:0]}),
    .rdata (img_rdata)
  );

  // multiply-accumulate pipe; taps outside the image are masked
  logic                            va_r, vp_r;
  logic signed [31:0]              prod_r;
  logic signed [cfe_pkg::ACC_W-1:0] acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vp_r <= 1'b0;
    end else begin
      va_r <= cmd.step && tap_ok;
      vp_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= $signed(wgt_rdata) * $signed(img_rdata);
    if (is_query)  acc_r <= cfe_pkg::ACC_W'(bias_r[in_out_chan]);
    else if (vp_r) acc_r <= acc_r + cfe_pkg::ACC_W'(prod_r);
  end

  assign stat.pipe_busy = va_r || vp_r;

  // round half up, drop 12 fraction bits, saturate to 24 bits
  logic signed [cfe_pkg::ACC_W-1:0]    acc_rnd;
  logic signed [cfe_pkg::ACC_W-13:0]   res;
  logic signed [23:0]                  res_sat;
  logic                                sat;
  always_comb begin
    acc_rnd = acc_r + cfe_pkg::ACC_W'(2048);
    res     = acc_rnd[cfe_pkg::ACC_W-1:12];
    sat     = 1'b1;
    if (res > cfe_pkg::ACC_W'(cfe_pkg::OUT_MAX))      res_sat = cfe_pkg::OUT_MAX;
    else if (res < cfe_pkg::ACC_W'(cfe_pkg::OUT_MIN)) res_sat = cfe_pkg::OUT_MIN;
    else begin
      res_sat = res[23:0];
      sat     = 1'b0;
    end
  end

  // result register
  logic               ov_r;
  logic signed [23:0] oval_r;
  logic               osat_r, ooor_r;

  assign stat.out_free = !ov_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n)            ov_r <= 1'b0;
    else if (cmd.load_out) ov_r <= 1'b1;
    else if (out_ready)    ov_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      oval_r <= oor_r ? 24'sd0 : res_sat;
      osat_r <= oor_r ? 1'b0 : sat;
      ooor_r <= oor_r;
    end
  end

  assign out_valid        = ov_r;
  assign out_conv_value   = oval_r;
  assign out_saturated    = osat_r;
  assign out_out_of_range = ooor_r;

endmodule

// ===== hdl/conv2d_forward_engine_top.sv =====
// top level of the convolution engine: controller, datapath and channel ports
//  channel | direction | handshake      | payload
//  in      | sink      | valid/ready    | kind, in_chan, out_chan, row_pos, col_pos, taps, value
//  out     | source    | valid/ready    | conv_value, saturated, out_of_range
//  cfg     | sink      | cfg_we         | cfg_index, cfg_data
// writes of samples, weights and biases are stored on acceptance and leave the engine idle.
// a query walks in_channel_count * kernel_side^2 taps (up to 100), lets the accumulate pipe
// drain and loads the result; an out-of-range query goes straight to the result load.
// after reset all 800 words of the weight store are cleared while in.ready stays low.
// a waiting result is held in the output register; the next request is taken meanwhile.
module conv2d_forward_engine_top (
  input  logic                       clk,
  input  logic                       rst_n,
  cfe_in_if.sink                     in,
  cfe_out_if.source                  out,
  input  logic                       cfg_we,
  input  logic [cfe_pkg::CFG_IW-1:0] cfg_index,
  input  logic [cfe_pkg::CFG_W-1:0]  cfg_data
);

  cfe_pkg::cfe_cmd_t  cmd;
  cfe_pkg::cfe_stat_t stat;

  cfe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in.valid),
    .in_kind  (in.kind),
    .in_ready (in.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  cfe_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_kind          (in.kind),
    .in_in_chan       (in.in_chan),
    .in_out_chan      (in.out_chan),
    .in_row_pos       (in.row_pos),
    .in_col_pos       (in.col_pos),
    .in_tap_row       (in.tap_row),
    .in_tap_col       (in.tap_col),
    .in_value         (in.value),
    .out_ready        (out.ready),
    .out_valid        (out.valid),
    .out_conv_value   (out.conv_value),
    .out_saturated    (out.saturated),
    .out_out_of_range (out.out_of_range),
    .cmd              (cmd),
    .stat             (stat)
  );

  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out.valid && out.out_of_range |-> out.conv_value == 24'sd0 && !out.saturated)
    else $error("out-of-range result carries a value");

  a_sat_extreme: assert property (@(posedge clk) disable iff (!rst_n)
    out.valid && out.saturated |->
      out.conv_value == cfe_pkg::OUT_MAX || out.conv_value == cfe_pkg::OUT_MIN)
    else $error("saturated result not at a limit");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out.valid && !in.ready)
    else $error("channels active right after reset");

endmodule
